// File: rtl/gds_pkg.sv
// Package: widths and constants of the divergence stencil block.
package gds_pkg;

    localparam int MAX_GRID   = 128;
    localparam int CNT_W      = $clog2(MAX_GRID);
    localparam int SIZE_W     = $clog2(MAX_GRID + 1);
    localparam int ADDR_W     = 1 + 2 * CNT_W;
    localparam int MEM_DEPTH  = 2 * MAX_GRID * MAX_GRID;
    localparam int MIN_GRID   = 3;
    localparam int SAMPLE_W   = 32;
    localparam int DIV_W      = 35;
    localparam int IDX_W      = 7;
    localparam int CFG_W      = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIV_W-1:0]    div_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [SIZE_W-1:0]          size_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [CFG_W-1:0]           cfg_t;

endpackage

// File: rtl/gds_in_if.sv
// Interfaces: sample input channel and divergence result channel.
interface gds_in_if import gds_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t u_sample;
    sample_t v_sample;
    sample_t w_sample;

    modport source (output valid, output u_sample, output v_sample, output w_sample,
                    input ready);
    modport sink (input valid, input u_sample, input v_sample, input w_sample,
                  output ready);
endinterface

interface gds_out_if import gds_pkg::*; ();
    logic valid;
    logic ready;
    div_t divergence;
    idx_t x_index;
    idx_t y_index;
    idx_t z_index;
    logic final_point;

    modport source (output valid, output divergence, output x_index, output y_index,
                    output z_index, output final_point, input ready);
    modport sink (input valid, input divergence, input x_index, input y_index,
                  input z_index, input final_point, output ready);
endinterface

// File: rtl/grid_divergence_stencil_top.sv
// Six-neighbour central-difference divergence over a streamed cubic grid. Samples
// (u,v,w) arrive in raster order (x fastest, then y, z), one per clock unless the
// output stalls. An interior point's divergence passes the stage-one and output
// registers once the sample one plane above it is taken; border points give nothing.
// The u and v memories take two reads and one write per cycle, allowing one sample
// per clock. The memories need no clearing after reset: every entry used in a result
// was written in the same grid. A grid-size write restarts the raster at the origin.
module grid_divergence_stencil_top import gds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_t      cfg_data,
    gds_in_if.sink    in_ch,
    gds_out_if.source out_ch
);

    size_t   n_reg;
    cnt_t    x_reg, x_next;
    cnt_t    y_reg, y_next;
    cnt_t    z_reg, z_next;

    sample_t u_mem [MEM_DEPTH];
    sample_t v_mem [MEM_DEPTH];
    sample_t w_mem [MEM_DEPTH];

    logic    s1_valid_reg;
    sample_t ue_reg, uw_reg, vn_reg, vs_reg, wd_reg, ws_reg;
    idx_t    s1_x_reg, s1_y_reg, s1_z_reg;
    logic    s1_final_reg;

    logic    out_valid_reg;
    div_t    out_div_reg;
    idx_t    out_x_reg, out_y_reg, out_z_reg;
    logic    out_final_reg;

    logic    in_fire, out_load;
    cnt_t    n_m1, n_m2;
    logic    emit;
    addr_t   wr_addr, ue_addr, uw_addr, vn_addr, vs_addr;
    logic    ps;
    div_t    sum;

    assign out_load     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || out_load;
    assign in_fire      = in_ch.valid && in_ch.ready;

    assign n_m1 = CNT_W'(n_reg - size_t'(1));
    assign n_m2 = CNT_W'(n_reg - size_t'(2));

    assign emit = (z_reg >= cnt_t'(2)) && (x_reg != '0) && (x_reg <= n_m2)
                  && (y_reg != '0) && (y_reg <= n_m2);

    // point plane z-1 has the opposite parity of the current plane
    assign ps      = ~z_reg[0];
    assign wr_addr = {z_reg[0], y_reg, x_reg};
    assign ue_addr = {ps, y_reg, x_reg + cnt_t'(1)};
    assign uw_addr = {ps, y_reg, x_reg - cnt_t'(1)};
    assign vn_addr = {ps, y_reg + cnt_t'(1), x_reg};
    assign vs_addr = {ps, y_reg - cnt_t'(1), x_reg};

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (in_fire)
        begin
            if (x_reg == n_m1)
            begin
                x_next = '0;
                if (y_reg == n_m1)
                begin
                    y_next = '0;
                    z_next = (z_reg == n_m1) ? '0 : z_reg + cnt_t'(1);
                end
                else
                begin
                    y_next = y_reg + cnt_t'(1);
                end
            end
            else
            begin
                x_next = x_reg + cnt_t'(1);
            end
        end
    end

    // hold the clamped grid size, step the raster per sample and restart it on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= SIZE_W'(MAX_GRID);
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (int'(cfg_data) < MIN_GRID)
                n_reg <= SIZE_W'(MIN_GRID);
            else if (int'(cfg_data) > MAX_GRID)
                n_reg <= SIZE_W'(MAX_GRID);
            else
                n_reg <= SIZE_W'(cfg_data);
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // read neighbors and store the new sample; reads see the old contents
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ue_reg <= u_mem[ue_addr];
            uw_reg <= u_mem[uw_addr];
            vn_reg <= v_mem[vn_addr];
            vs_reg <= v_mem[vs_addr];
            wd_reg <= w_mem[wr_addr];
            u_mem[wr_addr] <= in_ch.u_sample;
            v_mem[wr_addr] <= in_ch.v_sample;
            w_mem[wr_addr] <= in_ch.w_sample;
            ws_reg       <= in_ch.w_sample;
            s1_x_reg     <= IDX_W'(x_reg);
            s1_y_reg     <= IDX_W'(y_reg);
            s1_z_reg     <= IDX_W'(z_reg - cnt_t'(1));
            s1_final_reg <= (x_reg == n_m2) && (y_reg == n_m2) && (z_reg == n_m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= emit;
            else if (out_load)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sum = (div_t'(ue_reg) - div_t'(uw_reg)) + (div_t'(vn_reg) - div_t'(vs_reg))
                 + (div_t'(ws_reg) - div_t'(wd_reg));

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_div_reg   <= sum;
            out_x_reg     <= s1_x_reg;
            out_y_reg     <= s1_y_reg;
            out_z_reg     <= s1_z_reg;
            out_final_reg <= s1_final_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.divergence  = out_div_reg;
    assign out_ch.x_index     = out_x_reg;
    assign out_ch.y_index     = out_y_reg;
    assign out_ch.z_index     = out_z_reg;
    assign out_ch.final_point = out_final_reg;

endmodule
